// ----- hdl/esp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// esp_pkg: shared types and constants of the ellipsoid shell point projector
// Coordinate widths, register indexes, mode codes and the job record that
// travels from the classifier through the queue to the arithmetic back end.
// ---------------------------------------------------------------------------
package esp_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int AXIS_W    = COORD_W - 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int PQ_W      = 4 * COORD_W;
    localparam int T_W       = 6 * COORD_W;
    localparam int BIG_W     = 8 * COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_THREE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_B_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_B_NEG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_C     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE      = 3'd7;

    // operating modes
    localparam logic [1:0] MODE_ELL = 2'd0;
    localparam logic [1:0] MODE_PX  = 2'd1;
    localparam logic [1:0] MODE_PY  = 2'd2;
    localparam logic [1:0] MODE_PZ  = 2'd3;

    // one classified request; axis[set][axis], set 0 shrunk, 1 grown, 2 nominal
    typedef struct packed {
        logic                            direct;
        logic                            in_band;
        logic                            degen;
        logic                            band_ok;
        logic signed [COORD_W-1:0]       x;
        logic signed [COORD_W-1:0]       y;
        logic signed [COORD_W-1:0]       z;
        logic [2:0][2:0][COORD_W-1:0]    axis;
    } t_job;

endpackage
`default_nettype wire

// ----- hdl/esp_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// esp_front: configuration registers and request classifier
// Plane-mode and origin requests are resolved here and marked direct; the
// ellipsoid requests carry the three axis sets needed by the back end.
// ---------------------------------------------------------------------------
module esp_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [esp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [esp_pkg::COORD_W-1:0]        i_cfg_data,
    input  wire logic signed [esp_pkg::COORD_W-1:0] i_coord_x,
    input  wire logic signed [esp_pkg::COORD_W-1:0] i_coord_y,
    input  wire logic signed [esp_pkg::COORD_W-1:0] i_coord_z,
    output esp_pkg::t_job                           o_job
);
    import esp_pkg::*;

    logic [1:0]                r_mode;
    logic                      r_dim3;
    logic [AXIS_W-1:0]         r_semi_a;
    logic [AXIS_W-1:0]         r_semi_bp;
    logic [AXIS_W-1:0]         r_semi_bn;
    logic [AXIS_W-1:0]         r_semi_c;
    logic [AXIS_W-1:0]         r_band;
    logic signed [COORD_W-1:0] r_plane;

    logic signed [COORD_W-1:0] w_z;
    logic [AXIS_W-1:0]         w_a;
    logic [AXIS_W-1:0]         w_b;
    logic [AXIS_W-1:0]         w_c;
    logic [AXIS_W-1:0]         w_b_raw;
    logic                      w_band_ok;
    logic                      w_origin;
    logic signed [COORD_W+1:0] w_pv;
    logic signed [COORD_W+1:0] w_bd;
    logic signed [COORD_W+1:0] w_lo;
    logic signed [COORD_W+1:0] w_hi;
    logic signed [COORD_W+1:0] w_sel;
    logic                      w_slab;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ELL;
            r_dim3    <= 1'b1;
            r_semi_a  <= AXIS_W'(1) << FRAC_BITS;
            r_semi_bp <= AXIS_W'(1) << FRAC_BITS;
            r_semi_bn <= AXIS_W'(1) << FRAC_BITS;
            r_semi_c  <= AXIS_W'(1) << FRAC_BITS;
            r_band    <= '0;
            r_plane   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:       r_mode    <= i_cfg_data[1:0];
                CFG_DIM_THREE:  r_dim3    <= i_cfg_data[0];
                CFG_SEMI_A:     r_semi_a  <= i_cfg_data[AXIS_W-1:0];
                CFG_SEMI_B_POS: r_semi_bp <= i_cfg_data[AXIS_W-1:0];
                CFG_SEMI_B_NEG: r_semi_bn <= i_cfg_data[AXIS_W-1:0];
                CFG_SEMI_C:     r_semi_c  <= i_cfg_data[AXIS_W-1:0];
                CFG_BAND:       r_band    <= i_cfg_data[AXIS_W-1:0];
                CFG_PLANE:      r_plane   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // effective axes (zero register reads as one lsb)
    assign w_z      = r_dim3 ? i_coord_z : '0;
    assign w_b_raw  = (i_coord_y > 0) ? r_semi_bp : r_semi_bn;
    assign w_a      = (r_semi_a == '0) ? AXIS_W'(1) : r_semi_a;
    assign w_b      = (w_b_raw == '0) ? AXIS_W'(1) : w_b_raw;
    assign w_c      = !r_dim3 ? AXIS_W'(1) : ((r_semi_c == '0) ? AXIS_W'(1) : r_semi_c);
    assign w_band_ok = (r_band < w_a) && (r_band < w_b) && (!r_dim3 || (r_band < w_c));
    assign w_origin = (i_coord_x == '0) && (i_coord_y == '0) && (w_z == '0);

    // slab test on the selected axis
    assign w_pv = {{2{r_plane[COORD_W-1]}}, r_plane};
    assign w_bd = {3'b000, r_band};
    assign w_lo = w_pv - w_bd;
    assign w_hi = w_pv + w_bd;
    always_comb begin
        case (r_mode)
            MODE_PX: w_sel = {{2{i_coord_x[COORD_W-1]}}, i_coord_x};
            MODE_PY: w_sel = {{2{i_coord_y[COORD_W-1]}}, i_coord_y};
            default: w_sel = {{2{w_z[COORD_W-1]}}, w_z};
        endcase
    end
    assign w_slab = (w_sel >= w_lo) && (w_sel <= w_hi);

    // build the request record
    always_comb begin
        o_job         = '0;
        o_job.x       = i_coord_x;
        o_job.y       = i_coord_y;
        o_job.z       = w_z;
        o_job.band_ok = w_band_ok;
        o_job.axis[0][0] = {1'b0, w_a} - {1'b0, r_band};
        o_job.axis[0][1] = {1'b0, w_b} - {1'b0, r_band};
        o_job.axis[0][2] = r_dim3 ? ({1'b0, w_c} - {1'b0, r_band}) : COORD_W'(1);
        o_job.axis[1][0] = {1'b0, w_a} + {1'b0, r_band};
        o_job.axis[1][1] = {1'b0, w_b} + {1'b0, r_band};
        o_job.axis[1][2] = r_dim3 ? ({1'b0, w_c} + {1'b0, r_band}) : COORD_W'(1);
        o_job.axis[2][0] = {1'b0, w_a};
        o_job.axis[2][1] = {1'b0, w_b};
        o_job.axis[2][2] = {1'b0, w_c};
        unique case (r_mode)
            MODE_ELL: begin
                o_job.direct = w_origin;
                o_job.degen  = w_origin;
            end
            MODE_PX: begin
                o_job.direct  = 1'b1;
                o_job.in_band = w_slab;
                o_job.x       = r_plane;
            end
            MODE_PY: begin
                o_job.direct  = 1'b1;
                o_job.in_band = w_slab;
                o_job.y       = r_plane;
            end
            MODE_PZ: begin
                o_job.direct  = 1'b1;
                o_job.in_band = w_slab;
                o_job.z       = r_dim3 ? r_plane : '0;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/esp_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// esp_queue: short request queue between classifier and back end
// Four entries in flops; lets the front accept while the back end computes.
// ---------------------------------------------------------------------------
module esp_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire esp_pkg::t_job i_job,
    output logic         o_full,
    output logic         o_valid,
    output esp_pkg::t_job o_job,
    input  wire logic    i_pop
);
    import esp_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/esp_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// esp_back: exact shell test and radial projection
// A shift-add multiplier (one multiplier bit per cycle) steps through the
// products of up to three axis sets; a bit-serial square root then finds the
// largest q with q^2*N <= v^2*D for each coordinate.
// ---------------------------------------------------------------------------
module esp_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire esp_pkg::t_job                i_job,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_in_band,
    output logic signed [esp_pkg::COORD_W-1:0] o_out_x,
    output logic signed [esp_pkg::COORD_W-1:0] o_out_y,
    output logic signed [esp_pkg::COORD_W-1:0] o_out_z,
    output logic                              o_degenerate
);
    import esp_pkg::*;

    localparam int K_W      = $clog2(COORD_W);
    localparam int SB_SHIFT = 2 * (COORD_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [3:0] SP_SQ_X    = 4'd0;
    localparam logic [3:0] SP_SQ_Y    = 4'd1;
    localparam logic [3:0] SP_SQ_Z    = 4'd2;
    localparam logic [3:0] SP_SQ_P    = 4'd3;
    localparam logic [3:0] SP_SQ_Q    = 4'd4;
    localparam logic [3:0] SP_SQ_R    = 4'd5;
    localparam logic [3:0] SP_MUL_XQ  = 4'd6;
    localparam logic [3:0] SP_MAC_YP  = 4'd7;
    localparam logic [3:0] SP_MUL_TR  = 4'd8;
    localparam logic [3:0] SP_MUL_PQ  = 4'd9;
    localparam logic [3:0] SP_MAC_ZPQ = 4'd10;
    localparam logic [3:0] SP_MUL_DEN = 4'd11;
    localparam logic [3:0] SP_MUL_M   = 4'd12;

    localparam logic [1:0] SET_SHRUNK  = 2'd0;
    localparam logic [1:0] SET_GROWN   = 2'd1;
    localparam logic [1:0] SET_NOMINAL = 2'd2;

    logic [2:0]              r_state;
    logic [3:0]              r_step;
    logic [1:0]              r_set;
    logic [1:0]              r_coord;
    t_job                    r_job;
    logic                    r_inner;
    logic                    r_outer;
    logic [BIG_W-1:0]        r_acc;
    logic [BIG_W-1:0]        r_ma;
    logic [SQ_W-1:0]         r_mb;
    logic [SQ_W-1:0]         r_x2;
    logic [SQ_W-1:0]         r_y2;
    logic [SQ_W-1:0]         r_z2;
    logic [SQ_W-1:0]         r_sp;
    logic [SQ_W-1:0]         r_sq;
    logic [SQ_W-1:0]         r_sr;
    logic [PQ_W-1:0]         r_pq;
    logic [T_W-1:0]          r_t;
    logic [T_W-1:0]          r_den;
    logic [BIG_W-1:0]        r_rem;
    logic [BIG_W-1:0]        r_sa;
    logic [BIG_W-1:0]        r_sb;
    logic [COORD_W-1:0]      r_q;
    logic [K_W-1:0]          r_k;
    logic [COORD_W-1:0]      r_res [3];
    logic                    r_out_valid;
    logic                    r_out_in_band;
    logic                    r_out_degen;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] r_out_z;

    logic                    w_out_free;
    logic                    w_out_load;
    logic [COORD_W-1:0]      w_mag_x;
    logic [COORD_W-1:0]      w_mag_y;
    logic [COORD_W-1:0]      w_mag_z;
    logic [COORD_W-1:0]      w_p;
    logic [COORD_W-1:0]      w_qa;
    logic [COORD_W-1:0]      w_r;
    logic [BIG_W-1:0]        w_ma;
    logic [SQ_W-1:0]         w_mb;
    logic [BIG_W-1:0]        w_init;
    logic [SQ_W-1:0]         w_v2;
    logic [COORD_W-1:0]      w_v;
    logic [BIG_W:0]          w_cand;
    logic [BIG_W+1:0]        w_diff;
    logic [BIG_W+1:0]        w_grow;
    logic                    w_fit;
    logic [BIG_W-1:0]        w_sa_next;
    logic [COORD_W-1:0]      w_q_fin;
    logic [COORD_W-1:0]      w_lim;
    logic [COORD_W-1:0]      w_qc;
    logic [COORD_W-1:0]      w_res;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop = (r_state == ST_IDLE) && i_job_valid && (!i_job.direct || w_out_free);

    // output register takes a new result this cycle
    assign w_out_load = w_out_free &&
                        (((r_state == ST_IDLE) && i_job_valid && i_job.direct) ||
                         (r_state == ST_DONE));

    // magnitudes and the current axis set
    assign w_mag_x = r_job.x[COORD_W-1] ? (~r_job.x + 1'b1) : r_job.x;
    assign w_mag_y = r_job.y[COORD_W-1] ? (~r_job.y + 1'b1) : r_job.y;
    assign w_mag_z = r_job.z[COORD_W-1] ? (~r_job.z + 1'b1) : r_job.z;
    assign w_p  = r_job.axis[r_set][0];
    assign w_qa = r_job.axis[r_set][1];
    assign w_r  = r_job.axis[r_set][2];

    // coordinate under projection
    always_comb begin
        case (r_coord)
            2'd0:    begin w_v2 = r_x2; w_v = r_job.x; end
            2'd1:    begin w_v2 = r_y2; w_v = r_job.y; end
            default: begin w_v2 = r_z2; w_v = r_job.z; end
        endcase
    end

    // operand decoder for the multiply sequence
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_init = '0;
        unique case (r_step)
            SP_SQ_X:    begin w_ma = BIG_W'(w_mag_x); w_mb = SQ_W'(w_mag_x); end
            SP_SQ_Y:    begin w_ma = BIG_W'(w_mag_y); w_mb = SQ_W'(w_mag_y); end
            SP_SQ_Z:    begin w_ma = BIG_W'(w_mag_z); w_mb = SQ_W'(w_mag_z); end
            SP_SQ_P:    begin w_ma = BIG_W'(w_p);     w_mb = SQ_W'(w_p);     end
            SP_SQ_Q:    begin w_ma = BIG_W'(w_qa);    w_mb = SQ_W'(w_qa);    end
            SP_SQ_R:    begin w_ma = BIG_W'(w_r);     w_mb = SQ_W'(w_r);     end
            SP_MUL_XQ:  begin w_ma = BIG_W'(r_sq);    w_mb = r_x2;           end
            SP_MAC_YP:  begin
                w_ma = BIG_W'(r_sp); w_mb = r_y2; w_init = BIG_W'(r_t);
            end
            SP_MUL_TR:  begin w_ma = BIG_W'(r_t);     w_mb = r_sr;           end
            SP_MUL_PQ:  begin w_ma = BIG_W'(r_sp);    w_mb = r_sq;           end
            SP_MAC_ZPQ: begin
                w_ma = BIG_W'(r_pq); w_mb = r_z2; w_init = BIG_W'(r_t);
            end
            SP_MUL_DEN: begin w_ma = BIG_W'(r_pq);    w_mb = r_sr;           end
            SP_MUL_M:   begin w_ma = BIG_W'(r_den);   w_mb = w_v2;           end
            default:    ;
        endcase
    end

    // one square-root bit: try (q + 2^k)^2 * N against the remainder
    assign w_cand    = {1'b0, r_sa} + {1'b0, r_sb};
    assign w_diff    = {2'b00, r_rem} - {1'b0, w_cand};
    assign w_fit     = !w_diff[BIG_W+1];
    assign w_grow    = {1'b0, w_cand} + {2'b00, r_sb};
    assign w_sa_next = w_fit ? w_grow[BIG_W:1] : (r_sa >> 1);
    assign w_q_fin   = {r_q[COORD_W-2:0], w_fit};

    // saturate to the signed range and restore the sign
    assign w_lim = w_v[COORD_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    assign w_qc  = (w_q_fin > w_lim) ? w_lim : w_q_fin;
    assign w_res = w_v[COORD_W-1] ? (~w_qc + 1'b1) : w_qc;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.direct) begin
                            if (w_out_free) begin
                                r_out_in_band <= i_job.in_band;
                                r_out_degen   <= i_job.degen;
                                r_out_x       <= i_job.x;
                                r_out_y       <= i_job.y;
                                r_out_z       <= i_job.z;
                            end
                        end else begin
                            r_job   <= i_job;
                            r_step  <= SP_SQ_X;
                            r_set   <= i_job.band_ok ? SET_SHRUNK : SET_NOMINAL;
                            r_coord <= 2'd0;
                            r_inner <= 1'b0;
                            r_outer <= 1'b0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_acc   <= w_init;
                    r_ma    <= w_ma;
                    r_mb    <= w_mb;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_mb != '0) begin
                        r_acc <= r_mb[0] ? (r_acc + r_ma) : r_acc;
                        r_ma  <= r_ma << 1;
                        r_mb  <= r_mb >> 1;
                    end else begin
                        r_state <= ST_LOAD;
                        unique case (r_step)
                            SP_SQ_X:    begin r_x2 <= r_acc[SQ_W-1:0]; r_step <= SP_SQ_Y; end
                            SP_SQ_Y:    begin r_y2 <= r_acc[SQ_W-1:0]; r_step <= SP_SQ_Z; end
                            SP_SQ_Z:    begin r_z2 <= r_acc[SQ_W-1:0]; r_step <= SP_SQ_P; end
                            SP_SQ_P:    begin r_sp <= r_acc[SQ_W-1:0]; r_step <= SP_SQ_Q; end
                            SP_SQ_Q:    begin r_sq <= r_acc[SQ_W-1:0]; r_step <= SP_SQ_R; end
                            SP_SQ_R:    begin r_sr <= r_acc[SQ_W-1:0]; r_step <= SP_MUL_XQ; end
                            SP_MUL_XQ:  begin r_t <= r_acc[T_W-1:0]; r_step <= SP_MAC_YP; end
                            SP_MAC_YP:  begin r_t <= r_acc[T_W-1:0]; r_step <= SP_MUL_TR; end
                            SP_MUL_TR:  begin r_t <= r_acc[T_W-1:0]; r_step <= SP_MUL_PQ; end
                            SP_MUL_PQ:  begin r_pq <= r_acc[PQ_W-1:0]; r_step <= SP_MAC_ZPQ; end
                            SP_MAC_ZPQ: begin r_t <= r_acc[T_W-1:0]; r_step <= SP_MUL_DEN; end
                            SP_MUL_DEN: begin
                                r_den <= r_acc[T_W-1:0];
                                // shrunk set: on or outside; grown set: on or inside
                                if (r_set == SET_SHRUNK) r_inner <= (r_t >= r_acc[T_W-1:0]);
                                if (r_set == SET_GROWN)  r_outer <= (r_t <= r_acc[T_W-1:0]);
                                if (r_set == SET_NOMINAL) begin
                                    r_step  <= SP_MUL_M;
                                    r_coord <= 2'd0;
                                end else begin
                                    r_set  <= r_set + 2'd1;
                                    r_step <= SP_SQ_P;
                                end
                            end
                            SP_MUL_M: begin
                                r_rem   <= r_acc;
                                r_sa    <= '0;
                                r_sb    <= BIG_W'(r_t) << SB_SHIFT;
                                r_q     <= '0;
                                r_k     <= K_W'(COORD_W - 1);
                                r_state <= ST_SQRT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (w_fit) r_rem <= w_diff[BIG_W-1:0];
                    r_sa <= w_sa_next;
                    r_sb <= r_sb >> 2;
                    r_q  <= w_q_fin;
                    r_k  <= r_k - 1'b1;
                    if (r_k == '0) begin
                        r_res[r_coord] <= w_res;
                        if (r_coord == 2'd2) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_coord <= r_coord + 2'd1;
                            r_step  <= SP_MUL_M;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_in_band <= r_job.band_ok && r_inner && r_outer;
                        r_out_degen   <= 1'b0;
                        r_out_x       <= r_res[0];
                        r_out_y       <= r_res[1];
                        r_out_z       <= r_res[2];
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_in_band    = r_out_in_band;
    assign o_degenerate = r_out_degen;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_z      = r_out_z;

endmodule
`default_nettype wire

// ----- hdl/ellipsoid_shell_point_projector.sv -----
`default_nettype none
// Sequence: plane-mode and origin requests go from the queue straight into the output
//   register; ellipsoid requests run the shift-add multiplier (one bit per cycle) through
//   3 coordinate squares, 9 products per axis set for up to 3 sets, then per
//   coordinate one scaling product followed by a bit-serial square root.
// Throughput: the 4-entry queue takes one request per cycle until full; the back end
//   drains a direct request per cycle while the output is free, ellipsoid ones one at a time.
// ---------------------------------------------------------------------------
// ellipsoid_shell_point_projector: top level
// Classifier, request queue and arithmetic back end with a registered output.
// Reset: synchronous active low; registers return to one-unit axes, zero band, 3D.
// ---------------------------------------------------------------------------
module ellipsoid_shell_point_projector (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [esp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [esp_pkg::COORD_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [esp_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic signed [esp_pkg::COORD_W-1:0]  i_coord_y,
    input  wire logic signed [esp_pkg::COORD_W-1:0]  i_coord_z,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_in_band,
    output logic signed [esp_pkg::COORD_W-1:0]       o_out_x,
    output logic signed [esp_pkg::COORD_W-1:0]       o_out_y,
    output logic signed [esp_pkg::COORD_W-1:0]       o_out_z,
    output logic                                     o_degenerate
);
    import esp_pkg::*;

    t_job w_job_in;
    t_job w_job_q;
    logic w_q_full;
    logic w_q_valid;
    logic w_pop;
    logic w_push;

    assign o_in_ready = !w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    esp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .o_job       (w_job_in)
    );

    esp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_job_q),
        .i_pop   (w_pop)
    );

    esp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_q_valid),
        .i_job        (w_job_q),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_in_band    (o_in_band),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_degenerate (o_degenerate)
    );

    // a point at the origin can never lie inside the shell
    a_degen_not_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> !o_in_band)
        else $error("degenerate result flagged in band");

    // the back end only takes from a non-empty queue
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // a full queue must be holding requests
    a_full_has_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_q_valid)
        else $error("queue full but empty");

endmodule
`default_nettype wire
